// File: hw/rtl/imu_pkg.sv
// ----------------------------------------------------------------------------
// imu_pkg: shared types and constants of the integer multiply unit
// Operation codes, widths and the per-cell pipeline word.
// ----------------------------------------------------------------------------
package imu_pkg;

  localparam int unsigned OpW    = 3;
  localparam int unsigned DataW  = 64;
  localparam int unsigned DigitW = 16;          // multiplier bits per cell
  localparam int unsigned NumCells = 65 / DigitW + 1; // 5 cells cover 65 bits

  typedef enum logic [OpW-1:0] {
    OP_MUL    = 3'd0,
    OP_MULH   = 3'd1,
    OP_MULHSU = 3'd2,
    OP_MULHU  = 3'd3,
    OP_MULW   = 3'd4,
    OP_MULWU  = 3'd5
  } op_t;

  // Work carried from cell to cell
  typedef struct packed {
    logic [OpW-1:0]     func;
    logic [64:0]        mcand;   // sign/zero extended multiplicand
    logic [79:0]        mplier;  // extended multiplier, shifts down one digit per cell
    logic [129:0]       acc;     // partial sum, 2's complement
  } imu_work_t;

endpackage

// File: hw/rtl/imu_if.sv
// ----------------------------------------------------------------------------
// imu_in_if / imu_out_if: valid/ready channels of the multiply unit
// Input carries the op code and operands; output carries the product.
// ----------------------------------------------------------------------------
interface imu_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [63:0] operand_a;
  logic [63:0] operand_b;
  modport source (output valid, func, operand_a, operand_b, input ready);
  modport sink   (input valid, func, operand_a, operand_b, output ready);
endinterface

interface imu_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] product;
  modport source (output valid, product, input ready);
  modport sink   (input valid, product, output ready);
endinterface

// File: hw/rtl/imu_cell.sv
// ----------------------------------------------------------------------------
// imu_cell: one stage of the multiplier chain
// Adds one 16-bit multiplier digit times the multiplicand into the partial
// sum; the top cell weights its digit as signed to absorb the sign bit.
// ----------------------------------------------------------------------------
module imu_cell #(
  parameter int unsigned Index = 0,
  parameter bit          Last  = 1'b0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                vld_in,
  input  imu_pkg::imu_work_t  work_in,
  output logic                vld_out,
  output imu_pkg::imu_work_t  work_out
);
  import imu_pkg::*;

  logic               vld_r;
  imu_work_t          work_r, work_nxt;
  logic signed [81:0] pp;
  logic signed [16:0] dig;

  // One digit by the multiplicand: at most 17x65 bits
  always_comb begin
    if (Last) begin
      dig = {work_in.mplier[DigitW-1], work_in.mplier[DigitW-1:0]};
    end else begin
      dig = {1'b0, work_in.mplier[DigitW-1:0]};
    end
    pp = dig * $signed(work_in.mcand);
    work_nxt        = work_in;
    work_nxt.mplier = work_in.mplier >> DigitW;
    work_nxt.acc    = work_in.acc +
                      (130'({{48{pp[81]}}, pp}) << (Index * DigitW));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      work_r <= work_nxt;
    end
  end

  assign vld_out  = vld_r;
  assign work_out = work_r;
endmodule

// File: hw/rtl/integer_multiply_unit_top.sv
// ----------------------------------------------------------------------------
// integer_multiply_unit_top: RV64 M-extension multiplier
// Five-cell multiply chain with an output register.
// ----------------------------------------------------------------------------
// Takes one item per cycle while the chain is not stalled: five multiply
// cells each add one 16-bit digit of the 65-bit extended multiplier, then
// a result register selects the part of the 130-bit product. The whole
// chain stalls only when the output register holds an untaken result.
module integer_multiply_unit_top (
  input  logic           clk,
  input  logic           rst_n,
  imu_in_if.sink         in_ch,
  imu_out_if.source      out_ch
);
  import imu_pkg::*;

  logic                en;
  logic                vld   [NumCells+1];
  imu_work_t           work  [NumCells+1];
  logic                out_vld_r;
  logic [DataW-1:0]    out_prod_r, out_prod_nxt;
  logic                a_sgn, b_sgn;
  logic [64:0]         a_ext, b_ext;
  logic [129:0]        p;

  // Chain advances when the result slot is empty or being taken
  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // Operand extension per op code
  always_comb begin
    a_sgn = 1'b0;
    b_sgn = 1'b0;
    a_ext = {1'b0, in_ch.operand_a};
    b_ext = {1'b0, in_ch.operand_b};
    case (in_ch.func)
      OP_MULH: begin
        a_sgn = in_ch.operand_a[63];
        b_sgn = in_ch.operand_b[63];
      end
      OP_MULHSU: a_sgn = in_ch.operand_a[63];
      OP_MULW, OP_MULWU: begin
        a_ext = {33'd0, in_ch.operand_a[31:0]};
        b_ext = {33'd0, in_ch.operand_b[31:0]};
      end
      default: ;
    endcase
    if (a_sgn) a_ext[64] = 1'b1;
    if (b_sgn) b_ext[64] = 1'b1;
  end

  assign vld[0]         = in_ch.valid;
  assign work[0].func   = in_ch.func;
  assign work[0].mcand  = a_ext;
  assign work[0].mplier = {{15{b_ext[64]}}, b_ext};
  assign work[0].acc    = '0;

  genvar g;
  generate
    for (g = 0; g < NumCells; g++) begin : g_cell
      imu_cell #(.Index(g), .Last(g == NumCells - 1)) u_cell (
        .clk(clk), .rst_n(rst_n), .en(en),
        .vld_in(vld[g]), .work_in(work[g]),
        .vld_out(vld[g+1]), .work_out(work[g+1])
      );
    end
  endgenerate

  // Result selection
  assign p = work[NumCells].acc;
  always_comb begin
    case (work[NumCells].func)
      OP_MUL:                     out_prod_nxt = p[63:0];
      OP_MULH, OP_MULHSU, OP_MULHU: out_prod_nxt = p[127:64];
      OP_MULW:                    out_prod_nxt = {{32{p[31]}}, p[31:0]};
      OP_MULWU:                   out_prod_nxt = {32'd0, p[31:0]};
      default:                    out_prod_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld[NumCells];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_prod_r <= out_prod_nxt;
    end
  end

  assign out_ch.valid   = out_vld_r;
  assign out_ch.product = out_prod_r;

`ifndef ASSERT_OFF
  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ch.ready |=> out_vld_r && $stable(out_prod_r))
    else $error("result changed under stall");
  // Ready only when the result slot can move
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready == (!out_vld_r || out_ch.ready))
    else $error("ready mismatch");
  // Last cell valid moves to output when enabled
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    en && vld[NumCells] |=> out_vld_r)
    else $error("result lost");
`endif
endmodule
